FILE: design/mcls_pkg.sv
// shared types, constants and helpers for the mesh cell line splitter
package mcls_pkg;

  localparam int DEF_GRID_POINTS_X = 5;
  localparam int DEF_GRID_POINTS_Y = 5;
  localparam int COORD_W = 24;
  localparam int STEP_W = 23;
  localparam int MASK_W = 8;
  localparam int FEED_W = 24;
  localparam int FRAC_W = 16;
  localparam int LINE_W = 27;
  localparam int CFG_IDX_W = 2;
  localparam int IN_FIFO_DEPTH = 2;
  localparam int OUT_FIFO_DEPTH = 4;
  localparam logic [STEP_W-1:0] STEP_RESET = 23'd2560;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_STEP_X   = 2'd2,
    REG_STEP_Y   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t start_e;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    coord_t end_e;
    logic [FEED_W-1:0] feed_rate;
    logic [MASK_W-1:0] x_split_mask;
    logic [MASK_W-1:0] y_split_mask;
  } move_t;

  typedef struct packed {
    coord_t seg_x;
    coord_t seg_y;
    coord_t seg_z;
    coord_t seg_e;
    logic [FEED_W-1:0] seg_feed_rate;
    logic seg_last;
  } seg_t;

  // effective grid settings, zero step already replaced by one
  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
  } grid_cfg_t;

  // pending destination point with the masks that apply to it
  typedef struct packed {
    coord_t [3:0] p;
    logic [MASK_W-1:0] xm;
    logic [MASK_W-1:0] ym;
  } dest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_DECIDE,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_PUSH,
    ST_EMIT
  } eng_state_t;

  function automatic logic [STEP_W-1:0] step_eff(input logic [STEP_W-1:0] s);
    step_eff = (s == '0) ? STEP_W'(1) : s;
  endfunction

  function automatic logic signed [COORD_W:0] coord_diff(input coord_t a, input coord_t b);
    coord_diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W:0] v);
    logic signed [COORD_W:0] n;
    n = -v;
    mag = v[COORD_W] ? n[COORD_W-1:0] : v[COORD_W-1:0];
  endfunction

endpackage

FILE: design/mcls_fifo.sv
// small register queue used on both sides of the splitter
module mcls_fifo import mcls_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: design/mcls_divider.sv
// serial restoring divider for the q1.16 split fraction, one bit per cycle
module mcls_divider import mcls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] num,
  input  logic [COORD_W-1:0] den,
  output logic               done,
  output logic [FRAC_W:0]    quot
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [COORD_W:0] rem;
  logic [COORD_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [COORD_W:0] shifted;
  logic [COORD_W:0] diff;
  logic ge;
  logic ge0;

  // num never exceeds den: the integer bit is settled at start, then the remainder stays below den
  assign ge0 = (num >= den);
  assign shifted = {rem[COORD_W-1:0], 1'b0};
  assign diff = shifted - {1'b0, den_r};
  assign ge = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(FRAC_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= ge0 ? {1'b0, num - den} : {1'b0, num};
      den_r <= den;
      quot <= {{FRAC_W{1'b0}}, ge0};
    end else if (busy) begin
      rem <= ge ? diff : shifted;
      quot <= {quot[FRAC_W-1:0], ge};
    end
  end

endmodule

FILE: design/mcls_engine.sv
// back end: walks the pending destinations, splits at grid lines, emits segments
module mcls_engine import mcls_pkg::*; #(
  parameter int GRID_POINTS_X = DEF_GRID_POINTS_X,
  parameter int GRID_POINTS_Y = DEF_GRID_POINTS_Y
) (
  input  logic              clk,
  input  logic              rst,
  input  grid_cfg_t         grid,
  input  move_t             move_head,
  input  logic              move_empty,
  output logic              move_pop,
  output seg_t              seg_data,
  output logic              seg_push,
  input  logic              seg_full,
  output logic              div_start,
  output logic [COORD_W-1:0] div_num,
  output logic [COORD_W-1:0] div_den,
  input  logic              div_done,
  input  logic [FRAC_W:0]   div_quot
);

  localparam int CXW = (GRID_POINTS_X > 2) ? $clog2(GRID_POINTS_X - 1) : 1;
  localparam int CYW = (GRID_POINTS_Y > 2) ? $clog2(GRID_POINTS_Y - 1) : 1;
  localparam int SPLITS = GRID_POINTS_X + GRID_POINTS_Y - 4;
  localparam int DEPTH = (SPLITS + 1 > 2) ? SPLITS + 1 : 2;
  localparam int SIW = $clog2(DEPTH);
  localparam int SPW = $clog2(DEPTH + 1);
  localparam int PROD_W = COORD_W + 1 + FRAC_W + 1;

  eng_state_t state;
  eng_state_t state_next;

  dest_t stack [DEPTH];
  logic [SPW-1:0] sp;
  logic [SIW-1:0] top_idx;
  dest_t top;
  coord_t [3:0] cur;
  coord_t [3:0] mid;
  logic [FEED_W-1:0] feed;

  logic [CXW-1:0] scx, ecx, gcx;
  logic [CYW-1:0] scy, ecy, gcy;
  logic [CXW-1:0] scx_c, ecx_c;
  logic [CYW-1:0] scy_c, ecy_c;
  logic signed [LINE_W-1:0] line_x [GRID_POINTS_X-1];
  logic signed [LINE_W-1:0] line_y [GRID_POINTS_Y-1];

  logic x_ok, y_ok;
  logic split_y;
  coord_t line_val;
  coord_t line_sel;
  logic [MASK_W-1:0] xm_n, ym_n;
  logic [MASK_W-1:0] xm_red, ym_red;
  logic [FRAC_W:0] frac;
  logic [1:0] axis;
  logic signed [PROD_W-1:0] prod;
  logic signed [COORD_W:0] num_d, den_d, axis_d;
  logic signed [PROD_W-FRAC_W-1:0] sum;

  assign top_idx = SIW'(sp - SPW'(1));
  assign top = stack[top_idx];

  always_comb begin
    for (int k = 0; k < GRID_POINTS_X - 1; k++) begin
      line_x[k] = $signed(LINE_W'(grid.origin_x)) +
                  $signed(LINE_W'(k) * {{(LINE_W-STEP_W){1'b0}}, grid.step_x});
    end
    for (int k = 0; k < GRID_POINTS_Y - 1; k++) begin
      line_y[k] = $signed(LINE_W'(grid.origin_y)) +
                  $signed(LINE_W'(k) * {{(LINE_W-STEP_W){1'b0}}, grid.step_y});
    end
  end

  // cell index is the number of inner lines at or below the point
  always_comb begin
    scx_c = '0;
    ecx_c = '0;
    scy_c = '0;
    ecy_c = '0;
    for (int k = 1; k < GRID_POINTS_X - 1; k++) begin
      if ($signed(LINE_W'(cur[0])) >= line_x[k]) scx_c = scx_c + CXW'(1);
      if ($signed(LINE_W'(top.p[0])) >= line_x[k]) ecx_c = ecx_c + CXW'(1);
    end
    for (int k = 1; k < GRID_POINTS_Y - 1; k++) begin
      if ($signed(LINE_W'(cur[1])) >= line_y[k]) scy_c = scy_c + CYW'(1);
      if ($signed(LINE_W'(top.p[1])) >= line_y[k]) ecy_c = ecy_c + CYW'(1);
    end
  end

  assign gcx = (scx > ecx) ? scx : ecx;
  assign gcy = (scy > ecy) ? scy : ecy;
  assign x_ok = (scx != ecx) && top.xm[gcx];
  assign y_ok = (scy != ecy) && top.ym[gcy];
  assign line_sel = x_ok ? line_x[gcx][COORD_W-1:0] : line_y[gcy][COORD_W-1:0];

  // both halves carry the reduced masks
  assign xm_red = x_ok ? (top.xm & ~(MASK_W'(1) << gcx)) : top.xm;
  assign ym_red = (!x_ok && y_ok) ? (top.ym & ~(MASK_W'(1) << gcy)) : top.ym;

  always_comb begin
    if (x_ok) begin
      num_d = coord_diff(line_sel, cur[0]);
      den_d = coord_diff(top.p[0], cur[0]);
    end else begin
      num_d = coord_diff(line_sel, cur[1]);
      den_d = coord_diff(top.p[1], cur[1]);
    end
  end

  assign div_num = mag(num_d);
  assign div_den = mag(den_d);
  assign axis_d = coord_diff(top.p[axis], cur[axis]);
  assign sum = $signed((PROD_W-FRAC_W)'(cur[axis])) + prod[PROD_W-1:FRAC_W];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (!move_empty) state_next = ST_CELL;
      ST_CELL:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = (x_ok || y_ok) ? ST_DIV : ST_EMIT;
      ST_DIV:    if (div_done) state_next = ST_MUL;
      ST_MUL:    state_next = ST_ADD;
      ST_ADD:    state_next = (axis == 2'd3) ? ST_PUSH : ST_MUL;
      ST_PUSH:   state_next = ST_CELL;
      ST_EMIT: begin
        if (!seg_full) state_next = (sp == SPW'(1)) ? ST_IDLE : ST_CELL;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    move_pop = 1'b0;
    seg_push = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE:   move_pop = !move_empty;
      ST_DECIDE: div_start = x_ok || y_ok;
      ST_EMIT:   seg_push = !seg_full;
      default: begin
      end
    endcase
  end

  assign seg_data.seg_x = top.p[0];
  assign seg_data.seg_y = top.p[1];
  assign seg_data.seg_z = top.p[2];
  assign seg_data.seg_e = top.p[3];
  assign seg_data.seg_feed_rate = feed;
  assign seg_data.seg_last = (sp == SPW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sp <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE:  if (!move_empty) sp <= SPW'(1);
        ST_PUSH:  sp <= sp + SPW'(1);
        ST_EMIT:  if (!seg_full) sp <= sp - SPW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur[0] <= move_head.start_x;
        cur[1] <= move_head.start_y;
        cur[2] <= move_head.start_z;
        cur[3] <= move_head.start_e;
        stack[0].p[0] <= move_head.end_x;
        stack[0].p[1] <= move_head.end_y;
        stack[0].p[2] <= move_head.end_z;
        stack[0].p[3] <= move_head.end_e;
        stack[0].xm <= move_head.x_split_mask;
        stack[0].ym <= move_head.y_split_mask;
        feed <= move_head.feed_rate;
      end
      ST_CELL: begin
        scx <= scx_c;
        ecx <= ecx_c;
        scy <= scy_c;
        ecy <= ecy_c;
      end
      ST_DECIDE: begin
        split_y <= !x_ok;
        line_val <= line_sel;
        xm_n <= xm_red;
        ym_n <= ym_red;
        stack[top_idx].xm <= xm_red;
        stack[top_idx].ym <= ym_red;
        axis <= 2'd0;
      end
      ST_DIV: begin
        frac <= div_quot;
      end
      ST_MUL: begin
        prod <= PROD_W'(axis_d) * PROD_W'($signed({1'b0, frac}));
      end
      ST_ADD: begin
        // arithmetic shift floors the product
        if ((axis == 2'd0 && !split_y) || (axis == 2'd1 && split_y)) begin
          mid[axis] <= line_val;
        end else begin
          mid[axis] <= sum[COORD_W-1:0];
        end
        axis <= axis + 2'd1;
      end
      ST_PUSH: begin
        stack[SIW'(sp)].p <= mid;
        stack[SIW'(sp)].xm <= xm_n;
        stack[SIW'(sp)].ym <= ym_n;
      end
      ST_EMIT: begin
        if (!seg_full) cur <= top.p;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/mesh_cell_line_splitter.sv
// top level: grid registers, move queue, split engine, divider and segment queue
// Each move pushed in comes out as one or more segment end points in path order, the
// final one marked by seg_last. Each grid line split waits on the serial divider that
// forms the interpolation fraction, then uses one shared multiplier once per axis.
// A 5 by 5 grid allows at most six splits per move.
// Up to two moves wait in the input queue and four segments in the output queue, so
// moves may be pushed while earlier segments are still unread. Grid registers may be
// written only while no move is in flight.
module mesh_cell_line_splitter import mcls_pkg::*; #(
  parameter int GRID_POINTS_X = DEF_GRID_POINTS_X,
  parameter int GRID_POINTS_Y = DEF_GRID_POINTS_Y
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  move_t                move,
  input  logic                 pop,
  output logic                 empty,
  output seg_t                 seg,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  coord_t origin_x;
  coord_t origin_y;
  logic [STEP_W-1:0] step_x;
  logic [STEP_W-1:0] step_y;
  grid_cfg_t grid;

  move_t move_head;
  logic move_empty;
  logic move_pop;
  seg_t seg_data;
  logic seg_push;
  logic seg_full;
  logic div_start;
  logic [COORD_W-1:0] div_num;
  logic [COORD_W-1:0] div_den;
  logic div_done;
  logic [FRAC_W:0] div_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      step_x <= STEP_RESET;
      step_y <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_STEP_X:   step_x <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:   step_y <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign grid.origin_x = origin_x;
  assign grid.origin_y = origin_y;
  assign grid.step_x = step_eff(step_x);
  assign grid.step_y = step_eff(step_y);

  mcls_fifo #(
    .WIDTH($bits(move_t)),
    .DEPTH(IN_FIFO_DEPTH)
  ) u_move_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata(move),
    .full(full),
    .pop(move_pop),
    .rdata(move_head),
    .empty(move_empty)
  );

  mcls_engine #(
    .GRID_POINTS_X(GRID_POINTS_X),
    .GRID_POINTS_Y(GRID_POINTS_Y)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .grid(grid),
    .move_head(move_head),
    .move_empty(move_empty),
    .move_pop(move_pop),
    .seg_data(seg_data),
    .seg_push(seg_push),
    .seg_full(seg_full),
    .div_start(div_start),
    .div_num(div_num),
    .div_den(div_den),
    .div_done(div_done),
    .div_quot(div_quot)
  );

  mcls_divider u_divider (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(div_den),
    .done(div_done),
    .quot(div_quot)
  );

  mcls_fifo #(
    .WIDTH($bits(seg_t)),
    .DEPTH(OUT_FIFO_DEPTH)
  ) u_seg_fifo (
    .clk(clk),
    .rst(rst),
    .push(seg_push),
    .wdata(seg_data),
    .full(seg_full),
    .pop(pop),
    .rdata(seg),
    .empty(empty)
  );

endmodule

FILE: test/tb_mesh_cell_line_splitter.sv
// testbench for the mesh cell line splitter: random and directed moves checked per segment
module tb_mesh_cell_line_splitter;
  timeunit 1ns;
  timeprecision 1ps;
  import mcls_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 500;

  class seg_scoreboard;
    longint org_x, org_y, stp_x, stp_y;
    longint pos[4];
    logic [FEED_W-1:0] feed;
    seg_t move_segs[$];
    seg_t expected_segs[$];
    int mismatches;

    function new();
      org_x = 0;
      org_y = 0;
      stp_x = 2560;
      stp_y = 2560;
      mismatches = 0;
    endfunction

    function void set_grid(cfg_reg_t idx, logic [COORD_W-1:0] val);
      case (idx)
        REG_ORIGIN_X: org_x = longint'(coord_t'(val));
        REG_ORIGIN_Y: org_y = longint'(coord_t'(val));
        REG_STEP_X: stp_x = (val[STEP_W-1:0] == 0) ? 1 : longint'(val[STEP_W-1:0]);
        default: stp_y = (val[STEP_W-1:0] == 0) ? 1 : longint'(val[STEP_W-1:0]);
      endcase
    endfunction

    function int cell_of(longint p, longint o, longint st, int pts);
      longint n, q;
      n = p - o;
      q = n / st;
      if (n < 0 && (n % st) != 0) q--;
      if (q < 0) q = 0;
      if (q > pts - 2) q = pts - 2;
      return int'(q);
    endfunction

    function longint lerp(int ax, longint d, longint f);
      return pos[ax] + (((d - pos[ax]) * f) >>> 16);
    endfunction

    function void emit(longint p[4]);
      seg_t s;
      s.seg_x = coord_t'(p[0]);
      s.seg_y = coord_t'(p[1]);
      s.seg_z = coord_t'(p[2]);
      s.seg_e = coord_t'(p[3]);
      s.seg_feed_rate = feed;
      s.seg_last = 1'b0;
      move_segs.push_back(s);
      pos = p;
    endfunction

    function void split(longint dst[4], logic [7:0] xm, logic [7:0] ym);
      int scx, scy, ecx, ecy, gcx, gcy;
      longint mid[4];
      longint f;
      scx = cell_of(pos[0], org_x, stp_x, DEF_GRID_POINTS_X);
      scy = cell_of(pos[1], org_y, stp_y, DEF_GRID_POINTS_Y);
      ecx = cell_of(dst[0], org_x, stp_x, DEF_GRID_POINTS_X);
      ecy = cell_of(dst[1], org_y, stp_y, DEF_GRID_POINTS_Y);
      gcx = (scx > ecx) ? scx : ecx;
      gcy = (scy > ecy) ? scy : ecy;
      if (scx == ecx && scy == ecy) begin
        emit(dst);
        return;
      end
      if (ecx != scx && xm[gcx]) begin
        xm[gcx] = 1'b0;
        mid[0] = org_x + gcx * stp_x;
        f = ((mid[0] - pos[0]) * 65536) / (dst[0] - pos[0]);
        mid[1] = lerp(1, dst[1], f);
      end else if (ecy != scy && ym[gcy]) begin
        ym[gcy] = 1'b0;
        mid[1] = org_y + gcy * stp_y;
        f = ((mid[1] - pos[1]) * 65536) / (dst[1] - pos[1]);
        mid[0] = lerp(0, dst[0], f);
      end else begin
        emit(dst);
        return;
      end
      mid[2] = lerp(2, dst[2], f);
      mid[3] = lerp(3, dst[3], f);
      split(mid, xm, ym);
      split(dst, xm, ym);
    endfunction

    function void note_move(move_t m);
      longint dst[4];
      pos[0] = m.start_x;
      pos[1] = m.start_y;
      pos[2] = m.start_z;
      pos[3] = m.start_e;
      dst[0] = m.end_x;
      dst[1] = m.end_y;
      dst[2] = m.end_z;
      dst[3] = m.end_e;
      feed = m.feed_rate;
      move_segs.delete();
      split(dst, m.x_split_mask, m.y_split_mask);
      move_segs[move_segs.size()-1].seg_last = 1'b1;
      foreach (move_segs[i]) expected_segs.push_back(move_segs[i]);
    endfunction

    function void check_seg(seg_t s);
      seg_t e;
      if (expected_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment %p", s);
        return;
      end
      e = expected_segs.pop_front();
      if (s.seg_x !== e.seg_x || s.seg_y !== e.seg_y || s.seg_z !== e.seg_z ||
          s.seg_e !== e.seg_e || s.seg_feed_rate !== e.seg_feed_rate ||
          s.seg_last !== e.seg_last) begin
        mismatches++;
        if (mismatches <= 10) $display("segment mismatch: expected %p actual %p", e, s);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  move_t move = '0;
  logic pop = 1'b0;
  logic empty;
  seg_t seg;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;

  seg_scoreboard sb = new();
  int send_idle, recv_idle;
  bit hold_req = 0;
  int cycles = 0;

  mesh_cell_line_splitter dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .move(move),
    .pop(pop), .empty(empty), .seg(seg),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // segment receiver with random stalls and a single long hold-off requested in phase 4
  initial begin
    int hold_n;
    bit popping;
    hold_n = 0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        hold_n = 600;
      end
      if (hold_n > 0) begin
        hold_n--;
        popping = 0;
      end else begin
        popping = ($urandom_range(0, 99) >= recv_idle);
      end
      pop <= popping;
      @(posedge clk);
      if (popping && !empty) sb.check_seg(seg);
    end
  end

  task automatic send_move(move_t m);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    move <= m;
    do @(posedge clk); while (full);
    sb.note_move(m);
  endtask

  task automatic write_grid(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
                            logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
    logic [COORD_W-1:0] vals[4];
    vals = '{ox, oy, sx, sy};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_grid(cfg_reg_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic coord_t near_grid(longint o, longint st, int pts);
    longint v;
    if ($urandom_range(0, 9) == 0) return coord_t'($urandom);
    v = o + longint'($urandom) % ((pts + 1) * st) - st;
    if (v < -8388608) v = -8388608;
    if (v > 8388607) v = 8388607;
    return coord_t'(v);
  endfunction

  function automatic move_t rand_move();
    move_t m;
    logic [255:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    m = r[$bits(move_t)-1:0];
    m.start_x = near_grid(sb.org_x, sb.stp_x, DEF_GRID_POINTS_X);
    m.end_x = near_grid(sb.org_x, sb.stp_x, DEF_GRID_POINTS_X);
    m.start_y = near_grid(sb.org_y, sb.stp_y, DEF_GRID_POINTS_Y);
    m.end_y = near_grid(sb.org_y, sb.stp_y, DEF_GRID_POINTS_Y);
    if ($urandom_range(0, 3) != 0) begin
      m.x_split_mask = 8'hFF;
      m.y_split_mask = 8'hFF;
    end
    return m;
  endfunction

  function automatic move_t mk(longint sx, longint sy, longint ex, longint ey,
                               logic [7:0] xm, logic [7:0] ym);
    move_t m;
    m = rand_move();
    m.start_x = coord_t'(sx);
    m.start_y = coord_t'(sy);
    m.end_x = coord_t'(ex);
    m.end_y = coord_t'(ey);
    m.x_split_mask = xm;
    m.y_split_mask = ym;
    return m;
  endfunction

  task automatic directed_moves();
    move_t m;
    m = mk(-8388608, -8388608, 8388607, 8388607, 8'hFF, 8'hFF);
    m.start_z = coord_t'(-8388608); m.start_e = coord_t'(-8388608);
    m.end_z = 24'sd8388607; m.end_e = 24'sd8388607; m.feed_rate = '1;
    send_move(m);
    m = mk(8388607, 8388607, -8388608, -8388608, 8'hFF, 8'hFF);
    m.start_z = 24'sd8388607; m.start_e = 24'sd8388607;
    m.end_z = coord_t'(-8388608); m.end_e = coord_t'(-8388608); m.feed_rate = '0;
    send_move(m);
    send_move(mk(1000, 1000, 1000, 1000, 8'hFF, 8'hFF));
    send_move(mk(-100, -100, 10340, 10340, 8'hFF, 8'hFF));
    send_move(mk(10340, -100, -100, 10340, 8'hFF, 8'hFF));
    send_move(mk(-100, -100, 10340, 10340, 8'h00, 8'h00));
    send_move(mk(-100, 300, 10340, 300, 8'hFF, 8'h00));
    send_move(mk(300, 10340, 300, -100, 8'h00, 8'hFF));
    send_move(mk(-100, -100, 10340, 10340, 8'h55, 8'hAA));
    send_move(mk(-100, -100, 10340, 10340, 8'hAA, 8'h55));
    send_move(mk(2560, 2560, 5000, 7000, 8'hFF, 8'hFF));
    send_move(mk(5000, 7000, 2560, 2560, 8'hFF, 8'hFF));
    send_move(mk(1, 2, 10239, 3, 8'hFF, 8'hFF));
    send_move(mk(-30000, 4000, 40000, 4100, 8'hFF, 8'hFF));
    send_move(mk(7680, 0, 7679, 10240, 8'hFF, 8'hFF));
  endtask

  task automatic drain();
    while (sb.expected_segs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    send_idle = 29;
    recv_idle = 69;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 29 : (ph < 4) ? 69 : 0;
      recv_idle = (ph < 2) ? 69 : (ph < 4) ? 29 : 0;
      case (ph)
        1: write_grid(-24'sd1000, 24'sd500, '0, 24'd1);
        2: write_grid(COORD_W'(-8388608), 24'sd8388607, 24'd8388607, 24'd8388607);
        3: write_grid(COORD_W'($urandom_range(0, 40000) - 20000),
                      COORD_W'($urandom_range(0, 40000) - 20000),
                      COORD_W'($urandom_range(100, 20000)),
                      COORD_W'($urandom_range(100, 20000)));
        4: write_grid('0, '0, 24'd3000, 24'd700);
        5: write_grid(COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom_range(1, 8388607)),
                      COORD_W'($urandom_range(1, 2000000)));
        default: ;
      endcase
      if (ph == 0) directed_moves();
      if (ph == 4) hold_req = 1;
      for (int i = 0; i < 15; i++) send_move(rand_move());
      push <= 1'b0;
      drain();
    end
    if (sb.mismatches == 0 && sb.expected_segs.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
design/mcls_pkg.sv
design/mcls_fifo.sv
design/mcls_divider.sv
design/mcls_engine.sv
design/mesh_cell_line_splitter.sv
test/tb_mesh_cell_line_splitter.sv
